@@ design/assert_macros.svh @@
// assertion macros used by the checker file fxalu_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/fxalu_pkg.sv @@
// shared types and constants of the q16.16 arithmetic unit
// no dependencies
package fxalu_pkg;

  localparam int unsigned FixWidth   = 32;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned NumWidth   = FixWidth + FracBits;
  localparam int unsigned CmdWidth   = 2;
  localparam int unsigned InDataW    = 2 * FixWidth;
  localparam int unsigned OutDataW   = FixWidth;
  localparam int unsigned OutUserW   = 1;

  // divider steps per register stage, must divide NumWidth
  localparam int unsigned DivBitsPerStage = 2;

  // ieee single decoding
  localparam logic [31:0] MantMask  = 32'h007f_ffff;
  localparam logic [31:0] HiddenBit = 32'h0080_0000;
  localparam logic [31:0] ExpMask   = 32'h7f80_0000;
  localparam int unsigned ExpLsb    = 23;
  localparam int unsigned ExpBias   = 127;
  localparam int unsigned MantAlign = 7;
  localparam logic [7:0]  ExpPivot  = 8'(ExpBias + MantAlign);

  typedef enum logic [CmdWidth-1:0] {
    CMD_MUL   = 2'd0,
    CMD_DIV   = 2'd1,
    CMD_F2FIX = 2'd2,
    CMD_ABS   = 2'd3
  } cmd_e;

  // fields that ride alongside the divider pipeline
  typedef struct packed {
    logic                is_div;
    logic                neg;
    logic                dz;
    logic [FixWidth-1:0] simple;
  } side_t;

endpackage

@@ design/fxalu_div_pipe.sv @@
// pipelined restoring divider, a fixed number of quotient bits per stage
// depends on fxalu_pkg
module fxalu_div_pipe #(
  parameter int unsigned BitsPerStage = fxalu_pkg::DivBitsPerStage
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [fxalu_pkg::NumWidth-1:0]   num_i,
  input  logic [fxalu_pkg::FixWidth-1:0]   den_i,
  input  fxalu_pkg::side_t                 side_i,
  output logic                             valid_o,
  output logic [fxalu_pkg::FixWidth-1:0]   quot_o,
  output fxalu_pkg::side_t                 side_o
);

  localparam int unsigned NumW   = fxalu_pkg::NumWidth;
  localparam int unsigned DenW   = fxalu_pkg::FixWidth;
  localparam int unsigned Stages = NumW / BitsPerStage;

  logic                valid_in [Stages];
  logic [DenW-1:0]     rem_in   [Stages];
  logic [NumW-1:0]     num_in   [Stages];
  logic [DenW-1:0]     den_in   [Stages];
  fxalu_pkg::side_t    side_in  [Stages];

  logic                valid_q  [Stages];
  logic [DenW-1:0]     rem_q    [Stages];
  logic [NumW-1:0]     num_q    [Stages];
  logic [DenW-1:0]     den_q    [Stages];
  fxalu_pkg::side_t    side_q   [Stages];

  logic [DenW-1:0]     rem_d    [Stages];
  logic [NumW-1:0]     num_d    [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign valid_in[s] = valid_i;
      assign rem_in[s]   = '0;
      assign num_in[s]   = num_i;
      assign den_in[s]   = den_i;
      assign side_in[s]  = side_i;
    end else begin : g_next
      assign valid_in[s] = valid_q[s-1];
      assign rem_in[s]   = rem_q[s-1];
      assign num_in[s]   = num_q[s-1];
      assign den_in[s]   = den_q[s-1];
      assign side_in[s]  = side_q[s-1];
    end

    // quotient bits shift in at the bottom as numerator bits leave the top
    always_comb begin
      logic [DenW:0]   trial;
      logic [DenW-1:0] rem;
      logic [NumW-1:0] num;
      rem = rem_in[s];
      num = num_in[s];
      for (int k = 0; k < BitsPerStage; k++) begin
        trial = {rem, num[NumW-1]};
        num   = {num[NumW-2:0], 1'b0};
        if (trial >= {1'b0, den_in[s]}) begin
          trial  = trial - {1'b0, den_in[s]};
          num[0] = 1'b1;
        end
        rem = trial[DenW-1:0];
      end
      rem_d[s] = rem;
      num_d[s] = num;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= valid_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d[s];
        num_q[s]  <= num_d[s];
        den_q[s]  <= den_in[s];
        side_q[s] <= side_in[s];
      end
    end
  end

  assign valid_o = valid_q[Stages-1];
  assign quot_o  = num_q[Stages-1][DenW-1:0];
  assign side_o  = side_q[Stages-1];

endmodule

@@ design/fixed_point_16_16_alu_unit.sv @@
// top level of the signed q16.16 arithmetic unit
// depends on fxalu_pkg and fxalu_div_pipe
//
// usage:
//   s_axis carries one operation per transaction: tuser holds the command
//   (multiply, divide, float bits to fixed, absolute value), tdata holds
//   operand_a in the low word and operand_b in the high word.
//   m_axis returns exactly one result per operation, in order: tdata holds
//   the q16.16 result, tuser holds the divide_by_zero flag.
//   throughput: one transaction per cycle while m_axis is not stalled.
//   an accepted operation passes the input register, the decode register,
//   the divider stages and the output register before showing on m_axis.
//   every command runs through the same pipeline, so the divider's stage
//   count sets the latency of all commands.
//   when m_axis_tready is low while a result is shown, the whole pipeline
//   holds and s_axis_tready drops; nothing is lost or repeated.
//   reset clears all valid bits; no result is shown until one is accepted.
module fixed_point_16_16_alu_unit #(
  parameter int unsigned DivBitsPerStage = fxalu_pkg::DivBitsPerStage
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [31:0] operand_a, [63:32] operand_b
  input  logic [fxalu_pkg::InDataW-1:0]    s_axis_tdata_i,
  // [1:0] command
  input  logic [fxalu_pkg::CmdWidth-1:0]   s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [31:0] result
  output logic [fxalu_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // [0] divide_by_zero
  output logic [fxalu_pkg::OutUserW-1:0]   m_axis_tuser_o
);

  localparam int unsigned W = fxalu_pkg::FixWidth;
  localparam int unsigned F = fxalu_pkg::FracBits;

  logic en;

  // input stage
  logic                 valid_a_q;
  fxalu_pkg::cmd_e      cmd_a_q;
  logic [W-1:0]         a_a_q;
  logic [W-1:0]         b_a_q;

  // decode stage
  logic                 valid_b_q;
  logic [fxalu_pkg::NumWidth-1:0] num_b_q;
  logic [W-1:0]         den_b_q;
  fxalu_pkg::side_t     side_b_q;

  logic [fxalu_pkg::NumWidth-1:0] num_d;
  logic [W-1:0]         den_d;
  fxalu_pkg::side_t     side_d;

  logic signed [2*W-1:0] prod;
  logic [W-1:0]          mag_a;
  logic [W-1:0]          f2fix;

  // divider output
  logic                 valid_c;
  logic [W-1:0]         quot_c;
  fxalu_pkg::side_t     side_c;

  // output register
  logic                 out_valid_q;
  logic [W-1:0]         out_data_q;
  logic                 out_dz_q;
  logic [W-1:0]         out_data_d;

  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else if (en) begin
      valid_a_q <= s_axis_tvalid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd_a_q  <= fxalu_pkg::cmd_e'(s_axis_tuser_i);
      a_a_q    <= s_axis_tdata_i[W-1:0];
      b_a_q    <= s_axis_tdata_i[2*W-1:W];
      num_b_q  <= num_d;
      den_b_q  <= den_d;
      side_b_q <= side_d;
    end
  end

  assign prod  = $signed(a_a_q) * $signed(b_a_q);
  assign mag_a = a_a_q[W-1] ? (W'(0) - a_a_q) : a_a_q;

  // float bits to fixed: hidden bit restored, shifted by exponent minus pivot
  always_comb begin
    logic [W-1:0] mant;
    logic [7:0]   expo;
    logic [7:0]   sh;
    logic [W-1:0] v;
    mant = (a_a_q & fxalu_pkg::MantMask) | fxalu_pkg::HiddenBit;
    expo = 8'((a_a_q & fxalu_pkg::ExpMask) >> fxalu_pkg::ExpLsb);
    if (expo < fxalu_pkg::ExpPivot) begin
      sh = fxalu_pkg::ExpPivot - expo;
      v  = (sh >= 8'(W)) ? '0 : (mant >> sh[4:0]);
    end else begin
      sh = expo - fxalu_pkg::ExpPivot;
      v  = (sh >= 8'(W)) ? '0 : (mant << sh[4:0]);
    end
    f2fix = a_a_q[W-1] ? (W'(0) - v) : v;
  end

  always_comb begin
    logic [W-1:0] mag_b;
    mag_b         = b_a_q[W-1] ? (W'(0) - b_a_q) : b_a_q;
    num_d         = {mag_a, F'(0)};
    den_d         = mag_b;
    side_d.is_div = (cmd_a_q == fxalu_pkg::CMD_DIV);
    side_d.neg    = a_a_q[W-1] ^ b_a_q[W-1];
    side_d.dz     = (cmd_a_q == fxalu_pkg::CMD_DIV) && (b_a_q == '0);
    unique case (cmd_a_q)
      fxalu_pkg::CMD_MUL:   side_d.simple = prod[W+F-1:F];
      fxalu_pkg::CMD_F2FIX: side_d.simple = f2fix;
      fxalu_pkg::CMD_ABS:   side_d.simple = mag_a;
      default:              side_d.simple = '0;
    endcase
  end

  fxalu_div_pipe #(
    .BitsPerStage (DivBitsPerStage)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_b_q),
    .num_i   (num_b_q),
    .den_i   (den_b_q),
    .side_i  (side_b_q),
    .valid_o (valid_c),
    .quot_o  (quot_c),
    .side_o  (side_c)
  );

  always_comb begin
    priority if (side_c.dz) begin
      out_data_d = '0;
    end else if (side_c.is_div) begin
      out_data_d = side_c.neg ? (W'(0) - quot_c) : quot_c;
    end else begin
      out_data_d = side_c.simple;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
      out_dz_q   <= side_c.dz;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_dz_q;

endmodule

@@ design/fxalu_checker.sv @@
// port-level checks for the q16.16 arithmetic unit, bound to the top level
// depends on fxalu_pkg and assert_macros.svh
`include "assert_macros.svh"

module fxalu_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [fxalu_pkg::OutDataW-1:0]   m_axis_tdata_o,
  input logic [fxalu_pkg::OutUserW-1:0]   m_axis_tuser_o
);

  // a shown result stays until taken
  `ASSERT_CLKD(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o),
    "stalled result changed")

  // the input side only stalls while a result waits on the output
  `ASSERT_CLKD(a_ready_rule, clk_i, rst_ni,
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i),
    "input ready does not follow output stall")

  // a divide by zero always reports a zero result
  `ASSERT_CLKD(a_dz_zero, clk_i, rst_ni,
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o == '0,
    "divide by zero with nonzero result")

  // nothing is shown in the cycle right after reset
  `ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !m_axis_tvalid_o, "result valid after reset")

endmodule

bind fixed_point_16_16_alu_unit fxalu_checker u_fxalu_checker (.*);

@@ tb/testbench.sv @@
// self-checking testbench of the q16.16 arithmetic unit fixed_point_16_16_alu_unit
// depends on fxalu_pkg for the command enum and the width and ieee decoding constants
// directed edge cases per command, then a random mix with and without idle cycles
module testbench;
  import fxalu_pkg::*;

  localparam int unsigned PipeLatency = 26;
  localparam int unsigned DrainLimit  = 20000;

  typedef struct packed {
    logic [FixWidth-1:0] value;
    logic                dz;
  } fx_result_t;

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata  = '0;
  logic [CmdWidth-1:0] s_tuser  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic [OutUserW-1:0] m_tuser;

  fx_result_t  pending_results[$];
  bit          steady_flow = 1'b0;
  int unsigned errors = 0;
  int unsigned results_checked = 0;
  int unsigned ops_sent[4] = '{0, 0, 0, 0};

  fixed_point_16_16_alu_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    // [31:0] operand_a, [63:32] operand_b
    .s_axis_tdata_i  (s_tdata),
    // [1:0] command
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    // [31:0] result
    .m_axis_tdata_o  (m_tdata),
    // [0] divide_by_zero
    .m_axis_tuser_o  (m_tuser)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2400000;
    $display("FAIL");
    $finish;
  end

  function automatic fx_result_t alu_result(input cmd_e cmd, input logic [31:0] a,
                                            input logic [31:0] b);
    fx_result_t       r;
    logic signed [63:0] prod;
    logic [31:0]      mag_a;
    logic [31:0]      mag_b;
    logic [47:0]      num;
    logic [31:0]      mant;
    logic [31:0]      v;
    int               sh;
    r = '0;
    case (cmd)
      CMD_MUL: begin
        prod = 64'($signed(a)) * 64'($signed(b));
        r.value = prod[47:16];
      end
      CMD_DIV: begin
        if (b == '0) begin
          r.dz = 1'b1;
        end else begin
          mag_a = a[31] ? -a : a;
          mag_b = b[31] ? -b : b;
          num = {mag_a, 16'h0000};
          r.value = 32'(num / {16'h0000, mag_b});
          // strictly opposite signs; a zero dividend gives zero anyway
          if ((a[31] && !b[31]) || (!a[31] && a != '0 && b[31]))
            r.value = -r.value;
        end
      end
      CMD_F2FIX: begin
        mant = (a & MantMask) | HiddenBit;
        sh = int'(a[30:23]) - int'(ExpPivot);
        if (sh < 0)
          v = (-sh >= 32) ? '0 : mant >> (-sh);
        else
          v = (sh >= 32) ? '0 : mant << sh;
        r.value = a[31] ? -v : v;
      end
      default: begin
        r.value = a[31] ? -a : a;
      end
    endcase
    return r;
  endfunction

  task automatic issue_op(input cmd_e cmd, input logic [31:0] a, input logic [31:0] b);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      @(negedge clk_i);
      s_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= {b, a};
    s_tuser  <= cmd;
    do @(posedge clk_i); while (!s_tready);
    pending_results.push_back(alu_result(cmd, a, b));
    ops_sent[int'(cmd)]++;
  endtask

  // result side: random back-pressure outside steady flow, each transaction checked against the oldest entry
  initial begin
    fx_result_t  want;
    int unsigned stall;
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 15);
      repeat (stall) begin
        @(negedge clk_i);
        m_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending, actual %h dz %b", $time, m_tdata, m_tuser);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata !== want.value) begin
          $display("%0t: result mismatch, expected %h actual %h", $time, want.value, m_tdata);
          errors++;
        end
        if (m_tuser[0] !== want.dz) begin
          $display("%0t: divide_by_zero mismatch, expected %b actual %b", $time, want.dz,
                   m_tuser[0]);
          errors++;
        end
      end
      results_checked++;
    end
  end

  function automatic logic [31:0] rand_operand();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'h8000_0000;
      1: v = 32'h7fff_ffff;
      2: v = '0;
      3: v = 32'h0001_0000;
      4: begin
        v = 32'($urandom_range(0, 32'h0003_ffff));
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_float_bits();
    logic [31:0] v;
    v = $urandom;
    // keep most exponents near the range that gives nonzero results
    if ($urandom_range(0, 3) != 0)
      v[30:23] = 8'($urandom_range(98, 170));
    return v;
  endfunction

  task automatic test_multiply_edges();
    issue_op(CMD_MUL, 32'h0000_0000, 32'h0000_0000);
    issue_op(CMD_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    issue_op(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
    issue_op(CMD_MUL, 32'h8000_0000, 32'hffff_0000);
    issue_op(CMD_MUL, 32'h7fff_ffff, 32'h8000_0000);
    issue_op(CMD_MUL, 32'h0001_0000, 32'hdead_beef);
    issue_op(CMD_MUL, 32'hffff_ffff, 32'h0000_0001);
  endtask

  task automatic test_divide_edges();
    // zero divisor, with and without a zero dividend
    issue_op(CMD_DIV, 32'h1234_5678, 32'h0000_0000);
    issue_op(CMD_DIV, 32'h0000_0000, 32'h0000_0000);
    issue_op(CMD_DIV, 32'h8000_0000, 32'h8000_0000);
    issue_op(CMD_DIV, 32'h8000_0000, 32'h0000_0001);
    issue_op(CMD_DIV, 32'h7fff_ffff, 32'hffff_ffff);
    issue_op(CMD_DIV, 32'hfffe_8000, 32'h0002_0000);
    issue_op(CMD_DIV, 32'h0000_0000, 32'hffff_0000);
  endtask

  task automatic test_float_edges();
    issue_op(CMD_F2FIX, 32'h3f80_0000, '0);
    issue_op(CMD_F2FIX, 32'hc020_0000, '0);
    issue_op(CMD_F2FIX, 32'h0000_0000, '0);
    issue_op(CMD_F2FIX, 32'h4300_0000, '0);
    // left shifts of 31 and 32, right shifts of 31 and 32
    issue_op(CMD_F2FIX, 32'h52ff_ffff, '0);
    issue_op(CMD_F2FIX, 32'h5300_0000, '0);
    issue_op(CMD_F2FIX, 32'h33ff_ffff, '0);
    issue_op(CMD_F2FIX, 32'h337f_ffff, '0);
    // infinity and nan bit patterns are plain numbers here
    issue_op(CMD_F2FIX, 32'h7f80_0000, '0);
    issue_op(CMD_F2FIX, 32'hffff_ffff, '0);
  endtask

  task automatic test_abs_edges();
    issue_op(CMD_ABS, 32'h0000_0000, 32'hffff_ffff);
    issue_op(CMD_ABS, 32'h8000_0000, '0);
    issue_op(CMD_ABS, 32'h7fff_ffff, '0);
    issue_op(CMD_ABS, 32'hffff_ffff, '0);
  endtask

  task automatic test_random_mix(input int unsigned count);
    cmd_e        cmd;
    logic [31:0] a;
    logic [31:0] b;
    repeat (count) begin
      cmd = cmd_e'($urandom_range(0, 3));
      a = (cmd == CMD_F2FIX) ? rand_float_bits() : rand_operand();
      b = rand_operand();
      issue_op(cmd, a, b);
    end
  endtask

  initial begin
    int unsigned waited;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_multiply_edges();
    test_divide_edges();
    test_float_edges();
    test_abs_edges();
    // alternate idle-heavy and back-to-back stretches
    for (int i = 0; i < 4; i++) begin
      steady_flow = (i % 2 == 1);
      test_random_mix(300);
    end
    steady_flow = 1'b0;
    @(negedge clk_i);
    s_tvalid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      $display("FAIL");
      $finish;
    end else begin
      repeat (PipeLatency + 14) @(posedge clk_i);
      $display("sent %0d multiplies, %0d divides, %0d float conversions, %0d absolute values",
               ops_sent[0], ops_sent[1], ops_sent[2], ops_sent[3]);
      $display("checked %0d results under random idle and back-pressure, %0d mismatches",
               results_checked, errors);
      if (errors == 0) begin
        $display("PASS");
      end else begin
        $display("FAIL");
      end
      $finish;
    end
  end

endmodule
